FILE: rtl/mxtmr_pkg.sv
// Shared types, codes and defaults for the minimum-xor trie block.
package mxtmr_pkg;

    localparam int KEY_BITS_DEF = 31;
    localparam int MAX_KEYS_DEF = 1024;
    localparam int FIELD_W      = 31;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // One command per cycle from controller to datapath.
    typedef enum logic [3:0] {
        C_IDLE,
        C_LOAD,
        C_DISP,
        C_I1_STEP,
        C_I1_WAIT,
        C_I_CHK,
        C_I2_STEP,
        C_I2_WAIT,
        C_I2_FRESH,
        C_Q_STEP,
        C_Q_CHK,
        C_Q_TAKE,
        C_DONE
    } t_cmd;

    // Datapath status seen by the controller.
    typedef struct packed {
        t_op  op;
        logic live_full;
        logic live_zero;
        logic nxb_zero;
        logic last;
        logic rd_cnt_zero;
        logic no_room;
    } t_dp_st;

endpackage

FILE: rtl/mxtmr_node_mem.sv
// Trie node store: per-node count and child links, one write and one read port.
module mxtmr_node_mem
    import mxtmr_pkg::*;
#(
    parameter int DEPTH  = KEY_BITS_DEF * MAX_KEYS_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(MAX_KEYS_DEF + 1)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    input  logic                i_wr_cnt_en,
    input  logic                i_wr_link_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [CNT_W-1:0]    i_wr_cnt,
    input  logic [2*ADDR_W-1:0] i_wr_links,  // {link1, link0}
    output logic [CNT_W-1:0]    o_rd_cnt,
    output logic [2*ADDR_W-1:0] o_rd_links
);

    logic [CNT_W-1:0]    r_cnt_mem  [DEPTH];
    logic [2*ADDR_W-1:0] r_link_mem [DEPTH];
    logic [CNT_W-1:0]    r_rd_cnt;
    logic [2*ADDR_W-1:0] r_rd_links;

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt_en) begin
            r_cnt_mem[i_wr_addr] <= i_wr_cnt;
        end
        if (i_rd_en) begin
            r_rd_cnt <= r_cnt_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_link_en) begin
            r_link_mem[i_wr_addr] <= i_wr_links;
        end
        if (i_rd_en) begin
            r_rd_links <= r_link_mem[i_rd_addr];
        end
    end

    assign o_rd_cnt   = r_rd_cnt;
    assign o_rd_links = r_rd_links;

endmodule

FILE: rtl/mxtmr_datapath.sv
// Trie datapath: key, level, walk pointers, counters, node store and result registers.
module mxtmr_datapath
    import mxtmr_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [OP_W-1:0]    i_op,
    input  logic [FIELD_W-1:0] i_key,
    output t_dp_st             o_st,
    output logic [FIELD_W-1:0] o_xor,
    output logic [FIELD_W-1:0] o_match,
    output logic [STATUS_W-1:0] o_status
);

    localparam int DEPTH  = KEY_BITS * MAX_KEYS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FREE_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int LVL_W  = $clog2(KEY_BITS);
    localparam int NEED_W = $clog2(KEY_BITS + 1);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

    t_op                 r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_res;
    logic [LVL_W-1:0]    r_level;
    logic                r_cur_root;
    logic [ADDR_W-1:0]   r_cur;
    logic [ADDR_W-1:0]   r_addr;
    logic [2*ADDR_W-1:0] r_links;
    logic [2*ADDR_W-1:0] r_root_links;
    logic [FREE_W-1:0]   r_free;
    logic [CNT_W-1:0]    r_live;
    logic [NEED_W-1:0]   r_need;
    t_status             r_status;
    logic [FIELD_W-1:0]  r_out_xor;
    logic [FIELD_W-1:0]  r_out_match;
    t_status             r_out_status;

    logic [2*ADDR_W-1:0] cur_links;
    logic                b;
    logic [ADDR_W-1:0]   nxb;
    logic [ADDR_W-1:0]   nxo;
    logic                last;
    logic [LVL_W-1:0]    lvl_m1;
    logic [ADDR_W-1:0]   free_a;
    logic [ADDR_W-1:0]   new_child;
    logic [2*ADDR_W-1:0] fresh_links;
    logic [2*ADDR_W-1:0] parent_links;
    logic [FREE_W:0]     room_sum;
    logic [31:0]         key_ext;
    logic [31:0]         res_ext;
    logic [31:0]         xor_ext;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_cnt_en;
    logic                wr_link_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CNT_W-1:0]    wr_cnt;
    logic [2*ADDR_W-1:0] wr_links;
    logic [CNT_W-1:0]    rd_cnt;
    logic [2*ADDR_W-1:0] rd_links;

    mxtmr_node_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .i_wr_cnt_en  (wr_cnt_en),
        .i_wr_link_en (wr_link_en),
        .i_wr_addr    (wr_addr),
        .i_wr_cnt     (wr_cnt),
        .i_wr_links   (wr_links),
        .o_rd_cnt     (rd_cnt),
        .o_rd_links   (rd_links)
    );

    assign cur_links = r_cur_root ? r_root_links : r_links;
    assign b         = r_key[r_level];
    assign nxb       = b ? cur_links[2*ADDR_W-1:ADDR_W] : cur_links[ADDR_W-1:0];
    assign nxo       = b ? cur_links[ADDR_W-1:0] : cur_links[2*ADDR_W-1:ADDR_W];
    assign last      = (r_level == '0);
    assign lvl_m1    = r_level - LVL_W'(1);
    assign free_a    = r_free[ADDR_W-1:0];
    assign new_child = free_a + ADDR_W'(1);
    assign room_sum  = (FREE_W+1)'(r_free) + (FREE_W+1)'(r_need);
    assign key_ext   = 32'(i_key);
    assign res_ext   = 32'(r_res);
    assign xor_ext   = 32'(r_key ^ r_res);

    // Links of a freshly allocated node point at the next node on the chain.
    always_comb begin
        fresh_links = '0;
        if (!last) begin
            if (r_key[lvl_m1]) begin
                fresh_links = {new_child, ADDR_W'(0)};
            end else begin
                fresh_links = {ADDR_W'(0), new_child};
            end
        end
        parent_links = b ? {free_a, cur_links[ADDR_W-1:0]}
                         : {cur_links[2*ADDR_W-1:ADDR_W], free_a};
    end

    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = nxb;
        wr_cnt_en  = 1'b0;
        wr_link_en = 1'b0;
        wr_addr    = r_addr;
        wr_cnt     = rd_cnt + CNT_W'(1);
        wr_links   = parent_links;
        case (i_cmd)
            C_I1_STEP: begin
                rd_en = (nxb != '0) && !last;
            end
            C_I2_STEP: begin
                if (nxb != '0) begin
                    rd_en = 1'b1;
                end else if (!r_cur_root) begin
                    wr_link_en = 1'b1;
                    wr_addr    = r_cur;
                end
            end
            C_I2_WAIT: begin
                wr_cnt_en = 1'b1;
            end
            C_I2_FRESH: begin
                wr_cnt_en  = 1'b1;
                wr_link_en = 1'b1;
                wr_addr    = free_a;
                wr_cnt     = CNT_W'(1);
                wr_links   = fresh_links;
            end
            C_Q_STEP: begin
                rd_en   = 1'b1;
                rd_addr = (nxb != '0) ? nxb : nxo;
            end
            C_Q_CHK: begin
                if (rd_cnt != '0) begin
                    wr_cnt_en = 1'b1;
                    wr_cnt    = rd_cnt - CNT_W'(1);
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = nxo;
                end
            end
            C_Q_TAKE: begin
                wr_cnt_en = 1'b1;
                wr_cnt    = rd_cnt - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Walk state; payload registers need no reset.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_op       <= t_op'(i_op);
                r_key      <= key_ext[KEY_BITS-1:0];
                r_res      <= '0;
                r_level    <= LVL_TOP;
                r_cur_root <= 1'b1;
                r_need     <= '0;
                r_status   <= ST_OK;
            end
            C_DISP: begin
                if (r_op == OP_INSERT && r_live >= CNT_W'(MAX_KEYS)) begin
                    r_status <= ST_FULL;
                end else if (r_op == OP_QUERY && r_live == '0) begin
                    r_status <= ST_EMPTY;
                end
            end
            C_I1_STEP: begin
                if (nxb == '0) begin
                    r_need <= NEED_W'(r_level) + NEED_W'(1);
                end else if (!last) begin
                    r_addr  <= nxb;
                    r_level <= lvl_m1;
                end
            end
            C_I1_WAIT: begin
                r_links    <= rd_links;
                r_cur      <= r_addr;
                r_cur_root <= 1'b0;
            end
            C_I_CHK: begin
                if (room_sum > (FREE_W+1)'(DEPTH)) begin
                    r_status <= ST_FULL;
                end
                r_cur_root <= 1'b1;
                r_level    <= LVL_TOP;
            end
            C_I2_STEP: begin
                r_addr <= nxb;
            end
            C_I2_WAIT: begin
                r_links    <= rd_links;
                r_cur      <= r_addr;
                r_cur_root <= 1'b0;
                if (!last) begin
                    r_level <= lvl_m1;
                end
            end
            C_I2_FRESH: begin
                if (!last) begin
                    r_level <= lvl_m1;
                end
            end
            C_Q_STEP: begin
                if (nxb != '0) begin
                    r_addr <= nxb;
                end else begin
                    r_addr <= nxo;
                    r_res  <= {r_res[KEY_BITS-2:0], ~b};
                end
            end
            C_Q_CHK: begin
                if (rd_cnt != '0) begin
                    r_res      <= {r_res[KEY_BITS-2:0], b};
                    r_links    <= rd_links;
                    r_cur      <= r_addr;
                    r_cur_root <= 1'b0;
                    if (!last) begin
                        r_level <= lvl_m1;
                    end
                end else begin
                    r_addr <= nxo;
                    r_res  <= {r_res[KEY_BITS-2:0], ~b};
                end
            end
            C_Q_TAKE: begin
                r_links    <= rd_links;
                r_cur      <= r_addr;
                r_cur_root <= 1'b0;
                if (!last) begin
                    r_level <= lvl_m1;
                end
            end
            C_DONE: begin
                r_out_status <= r_status;
                if (r_op == OP_QUERY && r_status == ST_OK) begin
                    r_out_xor   <= xor_ext[FIELD_W-1:0];
                    r_out_match <= res_ext[FIELD_W-1:0];
                end else begin
                    r_out_xor   <= '0;
                    r_out_match <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Trie-wide state: root links, free pointer and key count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_links <= '0;
            r_free       <= FREE_W'(1);
            r_live       <= '0;
        end else begin
            case (i_cmd)
                C_DISP: begin
                    if (r_op == OP_CLEAR) begin
                        r_root_links <= '0;
                        r_free       <= FREE_W'(1);
                        r_live       <= '0;
                    end
                end
                C_I2_STEP: begin
                    if (nxb == '0 && r_cur_root) begin
                        r_root_links <= parent_links;
                    end
                end
                C_I2_WAIT: begin
                    if (last) begin
                        r_live <= r_live + CNT_W'(1);
                    end
                end
                C_I2_FRESH: begin
                    r_free <= r_free + FREE_W'(1);
                    if (last) begin
                        r_live <= r_live + CNT_W'(1);
                    end
                end
                C_Q_CHK: begin
                    if (rd_cnt != '0 && last) begin
                        r_live <= r_live - CNT_W'(1);
                    end
                end
                C_Q_TAKE: begin
                    if (last) begin
                        r_live <= r_live - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_st.op          = r_op;
    assign o_st.live_full   = (r_live >= CNT_W'(MAX_KEYS));
    assign o_st.live_zero   = (r_live == '0);
    assign o_st.nxb_zero    = (nxb == '0);
    assign o_st.last        = last;
    assign o_st.rd_cnt_zero = (rd_cnt == '0);
    assign o_st.no_room     = (room_sum > (FREE_W+1)'(DEPTH));

    assign o_xor    = r_out_xor;
    assign o_match  = r_out_match;
    assign o_status = r_out_status;

endmodule

FILE: rtl/mxtmr_ctrl.sv
// Trie controller: sequences insert, query and clear, and owns the handshakes.
module mxtmr_ctrl
    import mxtmr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_dp_st i_st,
    output t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_I1_STEP,
        S_I1_WAIT,
        S_I_CHK,
        S_I2_STEP,
        S_I2_WAIT,
        S_I2_FRESH,
        S_Q_STEP,
        S_Q_CHK,
        S_Q_TAKE,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = C_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd = C_DISP;
                if (i_st.op == OP_INSERT) begin
                    n_state = i_st.live_full ? S_DONE : S_I1_STEP;
                end else if (i_st.op == OP_QUERY) begin
                    n_state = i_st.live_zero ? S_DONE : S_Q_STEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_I1_STEP: begin
                o_cmd   = C_I1_STEP;
                n_state = (i_st.nxb_zero || i_st.last) ? S_I_CHK : S_I1_WAIT;
            end
            S_I1_WAIT: begin
                o_cmd   = C_I1_WAIT;
                n_state = S_I1_STEP;
            end
            S_I_CHK: begin
                o_cmd   = C_I_CHK;
                n_state = i_st.no_room ? S_DONE : S_I2_STEP;
            end
            S_I2_STEP: begin
                o_cmd   = C_I2_STEP;
                n_state = i_st.nxb_zero ? S_I2_FRESH : S_I2_WAIT;
            end
            S_I2_WAIT: begin
                o_cmd   = C_I2_WAIT;
                n_state = i_st.last ? S_DONE : S_I2_STEP;
            end
            S_I2_FRESH: begin
                o_cmd   = C_I2_FRESH;
                n_state = i_st.last ? S_DONE : S_I2_FRESH;
            end
            S_Q_STEP: begin
                o_cmd   = C_Q_STEP;
                n_state = i_st.nxb_zero ? S_Q_TAKE : S_Q_CHK;
            end
            S_Q_CHK: begin
                o_cmd = C_Q_CHK;
                if (i_st.rd_cnt_zero) begin
                    n_state = S_Q_TAKE;
                end else begin
                    n_state = i_st.last ? S_DONE : S_Q_STEP;
                end
            end
            S_Q_TAKE: begin
                o_cmd   = C_Q_TAKE;
                n_state = i_st.last ? S_DONE : S_Q_STEP;
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (out_free) begin
                    o_cmd       = C_DONE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/min_xor_trie_match_remove.sv
// Top level of the counted binary trie with minimum-xor query and removal.
//
// Usage:
//   Input beats carry one operation: tuser holds the opcode (insert, query
//   with removal, clear, no-op) and tdata the key or query value. Every
//   beat yields exactly one output beat with xor value, matched key and a
//   status (ok, query on empty trie, trie full at key limit or node store).
//   One operation is in flight at a time; a new input beat is taken as
//   soon as the controller is back in idle, even while the previous result
//   still waits in the output register.
//   Steps per operation, after the load:
//     insert  a checking walk, then a counting walk, one node access a
//             level; a fresh branch writes one new node a level
//     query   one walk from the root, into the matching child if its count is nonzero, else the other
//     clear, no-op, insert at the key limit, query on empty trie: no walk
//   Reset empties the trie at once (root links and counters are registers,
//   other nodes are written when allocated), so no clearing pass is run.
//   If the receiver stalls, the result holds in the output register; the
//   next operation still runs but holds its own result, stalling the input.
module min_xor_trie_match_remove
    import mxtmr_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] key_value, [31] zero pad
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [30:0] xor_value, [61:31] matched_key, pad
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    t_cmd                cmd;
    t_dp_st              dp_st;
    logic [FIELD_W-1:0]  out_xor;
    logic [FIELD_W-1:0]  out_match;
    logic [STATUS_W-1:0] out_status;

    // Sequence the walk and own both handshakes.
    mxtmr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_st        (dp_st),
        .o_cmd       (cmd)
    );

    // Hold the node store, walk pointers and the result register.
    mxtmr_datapath #(
        .KEY_BITS (KEY_BITS),
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_op     (i_s_axis_tuser),
        .i_key    (i_s_axis_tdata[FIELD_W-1:0]),
        .o_st     (dp_st),
        .o_xor    (out_xor),
        .o_match  (out_match),
        .o_status (out_status)
    );

    assign o_m_axis_tdata = {2'b00, out_match, out_xor};
    assign o_m_axis_tuser = out_status;

endmodule
